FILE: rtl/tlbd_pkg.sv
// tlbd_pkg: item types, request codes, state codes and priority encoders
// shared by the two-level bitmap directory; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tlbd_pkg;

  localparam int POS_W = 12;
  localparam int MAX_BITS = 64;
  localparam int IDX_W = 6;

  typedef enum logic [2:0] {
    REQ_SET       = 3'd0,
    REQ_CLEAR     = 3'd1,
    REQ_TEST      = 3'd2,
    REQ_HIGHEST   = 3'd3,
    REQ_LOWEST    = 3'd4,
    REQ_NEXT_UP   = 3'd5,
    REQ_NEXT_DOWN = 3'd6,
    REQ_CLEAR_ALL = 3'd7
  } req_kind_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   result_position;
    logic               any_occupied;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_RD1,
    ST_EV1,
    ST_RD2,
    ST_EV2
  } ctl_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctl_stat_t;

  function automatic logic [IDX_W-1:0] lsb_idx(input logic [MAX_BITS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] msb_idx(input logic [MAX_BITS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_BITS; i++) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tlbd_word_ram.sv
// tlbd_word_ram: lower-level occupancy words, one write and one read port,
// registered read data; stand-alone
`timescale 1ns / 1ps
`default_nettype none

module tlbd_word_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/tlbd_ctrl.sv
// tlbd_ctrl: sequencer, summary word and word evaluation for the directory
// uses tlbd_pkg; drives the ports of tlbd_word_ram
`timescale 1ns / 1ps
`default_nettype none

module tlbd_ctrl
  import tlbd_pkg::*;
#(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire req_t                          req,
  input  wire logic                          slot_free,
  output ctl_stat_t                          stat,
  output res_t                               result,
  output logic                               wr_en,
  output logic [$clog2(WORD_COUNT)-1:0]      wr_addr,
  output logic [WORD_BITS-1:0]               wr_data,
  output logic                               rd_en,
  output logic [$clog2(WORD_COUNT)-1:0]      rd_addr,
  input  wire logic [WORD_BITS-1:0]          rd_data
);

  localparam int WI = $clog2(WORD_COUNT);
  localparam int BI = $clog2(WORD_BITS);
  localparam int RSH = 20;
  localparam int RECIP = (1 << RSH) / WORD_BITS;
  localparam logic [POS_W-1:0] WB_P = POS_W'(WORD_BITS);
  localparam logic [POS_W:0] TOTAL = (POS_W + 1)'(WORD_BITS * WORD_COUNT);

  ctl_state_t state, state_next;

  req_kind_t              kind;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       q_est;
  logic [POS_W-1:0]       word_pos;
  logic [BI-1:0]          bidx;
  logic                   in_range;
  logic [WI-1:0]          cur_word;
  logic [WORD_COUNT-1:0]  summary;

  logic [31:0]            prod;
  logic [POS_W-1:0]       qm;
  logic [POS_W-1:0]       r_raw;

  logic                   eff_high;
  logic [WI-1:0]          addr1;
  logic [WORD_BITS-1:0]   data_eff;
  logic [WORD_BITS-1:0]   onehot;
  logic [WORD_BITS-1:0]   above_m;
  logic [WORD_BITS-1:0]   below_m;
  logic [WORD_COUNT-1:0]  wabove_m;
  logic [WORD_COUNT-1:0]  wbelow_m;
  logic [WORD_BITS-1:0]   up_m;
  logic [WORD_BITS-1:0]   dn_m;
  logic [WORD_COUNT-1:0]  sum_up;
  logic [WORD_COUNT-1:0]  sum_dn;
  logic                   any_now;
  logic                   none_up;
  logic                   none_dn;

  logic                   need2;
  logic [WI-1:0]          addr2;
  logic                   wr_req;
  logic                   done;
  logic [WORD_COUNT-1:0]  summary_next;
  logic                   res_found;
  logic [POS_W-1:0]       res_pos;

  function automatic logic [POS_W-1:0] make_pos(input logic [WI-1:0] w,
                                                 input logic [IDX_W-1:0] b);
    return POS_W'(POS_W'(w) * WB_P + POS_W'(b));
  endfunction

  // word index by reciprocal multiply, corrected in the split step
  assign prod = 32'(req.position) * 32'(RECIP);

  assign qm    = POS_W'(q_est * WB_P);
  assign r_raw = pos_r - qm;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= req.req_type;
      pos_r <= req.position;
      q_est <= prod[RSH +: POS_W];
    end
    if (state == ST_SPLIT) begin
      in_range <= {1'b0, pos_r} < TOTAL;
      if (r_raw >= WB_P) begin
        word_pos <= q_est + POS_W'(1);
        bidx     <= BI'(r_raw - WB_P);
      end else begin
        word_pos <= q_est;
        bidx     <= BI'(r_raw);
      end
    end
    if (state == ST_RD1) cur_word <= addr1;
    else if (state == ST_EV1 && need2) cur_word <= addr2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      summary <= '0;
    end else begin
      state <= state_next;
      if (done) summary <= summary_next;
    end
  end

  // a clear summary bit means the word is empty, whatever the memory holds
  assign data_eff = summary[cur_word] ? rd_data : '0;
  assign eff_high = (kind == REQ_HIGHEST) || (kind == REQ_NEXT_DOWN && !in_range);
  assign any_now  = |summary;
  assign none_up  = !any_now || (({1'b0, pos_r} + (POS_W + 1)'(1)) >= TOTAL);
  assign none_dn  = !any_now || (pos_r == '0);

  always_comb begin
    if (eff_high) addr1 = WI'(msb_idx(MAX_BITS'(summary)));
    else if (kind == REQ_LOWEST) addr1 = WI'(lsb_idx(MAX_BITS'(summary)));
    else addr1 = word_pos[WI-1:0];
  end

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      above_m[i] = i > int'(bidx);
      below_m[i] = i < int'(bidx);
    end
    for (int j = 0; j < WORD_COUNT; j++) begin
      wabove_m[j] = j > int'(cur_word);
      wbelow_m[j] = j < int'(cur_word);
    end
  end

  assign onehot = WORD_BITS'(1) << bidx;
  assign up_m   = data_eff & above_m;
  assign dn_m   = data_eff & below_m;
  assign sum_up = summary & wabove_m;
  assign sum_dn = summary & wbelow_m;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_SPLIT;
      ST_SPLIT: state_next = ST_RD1;
      ST_RD1:   state_next = ST_EV1;
      ST_EV1: begin
        if (need2) state_next = ST_RD2;
        else if (done) state_next = ST_IDLE;
      end
      ST_RD2:   state_next = ST_EV2;
      ST_EV2:   if (done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = cur_word;
    wr_req       = 1'b0;
    wr_data      = data_eff | onehot;
    need2        = 1'b0;
    addr2        = cur_word;
    summary_next = summary;
    res_found    = 1'b0;
    res_pos      = '0;
    done         = 1'b0;
    case (state)
      ST_RD1: begin
        rd_en   = 1'b1;
        rd_addr = addr1;
      end
      ST_RD2: begin
        rd_en = 1'b1;
      end
      ST_EV1: begin
        case (kind)
          REQ_SET: begin
            if (in_range) begin
              wr_req                 = 1'b1;
              summary_next[cur_word] = 1'b1;
            end
          end
          REQ_CLEAR: begin
            wr_data = data_eff & ~onehot;
            if (in_range) begin
              wr_req                 = 1'b1;
              summary_next[cur_word] = |(data_eff & ~onehot);
            end
          end
          REQ_TEST: begin
            res_found = in_range && data_eff[bidx];
          end
          REQ_HIGHEST: begin
            res_found = any_now;
            if (any_now) res_pos = make_pos(cur_word, msb_idx(MAX_BITS'(data_eff)));
          end
          REQ_LOWEST: begin
            res_found = any_now;
            if (any_now) res_pos = make_pos(cur_word, lsb_idx(MAX_BITS'(data_eff)));
          end
          REQ_NEXT_UP: begin
            if (!none_up) begin
              if (|up_m) begin
                res_found = 1'b1;
                res_pos   = make_pos(cur_word, lsb_idx(MAX_BITS'(up_m)));
              end else if (|sum_up) begin
                need2 = 1'b1;
                addr2 = WI'(lsb_idx(MAX_BITS'(sum_up)));
              end
            end
          end
          REQ_NEXT_DOWN: begin
            if (!in_range) begin
              // beyond the store every position lies below: same as highest
              res_found = any_now;
              if (any_now) res_pos = make_pos(cur_word, msb_idx(MAX_BITS'(data_eff)));
            end else if (!none_dn) begin
              if (|dn_m) begin
                res_found = 1'b1;
                res_pos   = make_pos(cur_word, msb_idx(MAX_BITS'(dn_m)));
              end else if (|sum_dn) begin
                need2 = 1'b1;
                addr2 = WI'(msb_idx(MAX_BITS'(sum_dn)));
              end
            end
          end
          REQ_CLEAR_ALL: begin
            summary_next = '0;
          end
          default: ;
        endcase
        done = !need2 && slot_free;
      end
      ST_EV2: begin
        res_found = 1'b1;
        if (kind == REQ_NEXT_UP) res_pos = make_pos(cur_word, lsb_idx(MAX_BITS'(data_eff)));
        else res_pos = make_pos(cur_word, msb_idx(MAX_BITS'(data_eff)));
        done = slot_free;
      end
      default: ;
    endcase
  end

  // writes land only in the finishing step, before the next item's read
  assign wr_en   = wr_req && done;
  assign wr_addr = cur_word;

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = done;

  assign result.found           = res_found;
  assign result.result_position = res_pos;
  assign result.any_occupied    = |summary_next;

  a_write_in_eval: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_EV1)
    else $error("word write outside first evaluation step");

  a_done_needs_slot: assert property (@(posedge clk) disable iff (rst)
    done |-> slot_free)
    else $error("result finished with output register full");

  a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("read and write of word memory in one cycle");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after result");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == ST_IDLE)
    else $error("item taken while busy");

endmodule

`default_nettype wire

FILE: rtl/two_level_bitmap_priority_directory.sv
// two_level_bitmap_priority_directory: top level, output register and wiring
// uses tlbd_pkg, tlbd_ctrl and tlbd_word_ram
//
//   channel | signals                  | moves
//   req     | req_valid, req_stall, req | request item (req_type, position)
//   res     | res_valid, res_stall, res | result item (found, position, any)
//
// one item at a time: split the position, read the word, evaluate, then
// register the result; the next item is taken back in idle; a next search
// that must move on to another word reads and evaluates that word in turn,
// since the word memory has one read port
// reset clears the summary word, which marks every word empty at once
// a stalled result holds in the output register; the next item is taken
// meanwhile and waits in its final step until the register is free
`timescale 1ns / 1ps
`default_nettype none

module two_level_bitmap_priority_directory
  import tlbd_pkg::*;
#(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  localparam int WI = $clog2(WORD_COUNT);

  ctl_stat_t             stat;
  res_t                  ctl_res;
  logic                  accept;
  logic                  slot_free;
  logic                  wr_en;
  logic [WI-1:0]         wr_addr;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  rd_en;
  logic [WI-1:0]         rd_addr;
  logic [WORD_BITS-1:0]  rd_data;

  assign req_stall = !stat.idle;
  assign accept    = req_valid && !req_stall;
  assign slot_free = !res_valid || !res_stall;

  tlbd_ctrl #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .slot_free (slot_free),
    .stat      (stat),
    .result    (ctl_res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  tlbd_word_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stat.done) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) res <= ctl_res;
  end

endmodule

`default_nettype wire

FILE: bench/two_level_bitmap_priority_directory_tb.sv
// two_level_bitmap_priority_directory_tb: self-checking bench for the bitmap directory,
// with a queue-fed request driver, a result monitor and its own model of both bitmap levels
// depends on tlbd_pkg and two_level_bitmap_priority_directory
`timescale 1ns / 1ps

module two_level_bitmap_priority_directory_tb;
  import tlbd_pkg::*;

  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // shadow copy of the directory: lower words and the summary word
  logic [63:0] occ_words [64] = '{default: '0};
  logic [63:0] occ_summary = '0;

  req_t req_backlog [$];
  res_t expected_results [$];
  logic [11:0] hot_pos [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  res_t want;

  two_level_bitmap_priority_directory i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [5:0] low_bit(input logic [63:0] v);
    int i;
    i = 0;
    while (i < 63 && !v[i]) i++;
    return 6'(i);
  endfunction

  function automatic logic [5:0] high_bit(input logic [63:0] v);
    int i;
    i = 63;
    while (i > 0 && !v[i]) i--;
    return 6'(i);
  endfunction

  // applies one request to the shadow directory and returns the result item it gives
  function automatic res_t predict_directory_result(input req_t r);
    logic [5:0] w;
    logic [5:0] b;
    logic [5:0] w2;
    logic [63:0] m;
    res_t o;
    w = r.position[11:6];
    b = r.position[5:0];
    o = '0;
    case (r.req_type)
      REQ_SET: begin
        occ_words[w][b] = 1'b1;
        occ_summary[w] = 1'b1;
      end
      REQ_CLEAR: begin
        occ_words[w][b] = 1'b0;
        if (occ_words[w] == '0) occ_summary[w] = 1'b0;
      end
      REQ_TEST: o.found = occ_words[w][b];
      REQ_HIGHEST: begin
        if (occ_summary != '0) begin
          w2 = high_bit(occ_summary);
          o.found = 1'b1;
          o.result_position = {w2, high_bit(occ_words[w2])};
        end
      end
      REQ_LOWEST: begin
        if (occ_summary != '0) begin
          w2 = low_bit(occ_summary);
          o.found = 1'b1;
          o.result_position = {w2, low_bit(occ_words[w2])};
        end
      end
      REQ_NEXT_UP: begin
        if (occ_summary != '0 && r.position != 12'hfff) begin
          // bits strictly above b in the same word, then the next nonempty word up
          m = occ_words[w] & ~((64'd2 << b) - 64'd1);
          if (m != '0) begin
            o.found = 1'b1;
            o.result_position = {w, low_bit(m)};
          end else begin
            m = occ_summary & ~((64'd2 << w) - 64'd1);
            if (m != '0) begin
              w2 = low_bit(m);
              o.found = 1'b1;
              o.result_position = {w2, low_bit(occ_words[w2])};
            end
          end
        end
      end
      REQ_NEXT_DOWN: begin
        if (occ_summary != '0 && r.position != '0) begin
          m = occ_words[w] & ((64'd1 << b) - 64'd1);
          if (m != '0) begin
            o.found = 1'b1;
            o.result_position = {w, high_bit(m)};
          end else begin
            m = occ_summary & ((64'd1 << w) - 64'd1);
            if (m != '0) begin
              w2 = high_bit(m);
              o.found = 1'b1;
              o.result_position = {w2, high_bit(occ_words[w2])};
            end
          end
        end
      end
      REQ_CLEAR_ALL: begin
        occ_summary = '0;
        for (int i = 0; i < 64; i++) occ_words[i] = '0;
      end
      default: ;
    endcase
    o.any_occupied = (occ_summary != '0);
    return o;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) expected_results.push_back(predict_directory_result(req));
      if (!req_valid || !req_stall) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          req_valid <= 1'b1;
          req <= req_backlog.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, with an occasional long hold
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_ask) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      res_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $error("result item with no request outstanding: %p", res);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (res.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, res.found);
          errors++;
        end
        if (res.result_position !== want.result_position) begin
          $error("result_position: expected %0d, got %0d", want.result_position,
                 res.result_position);
          errors++;
        end
        if (res.any_occupied !== want.any_occupied) begin
          $error("any_occupied: expected %0d, got %0d", want.any_occupied, res.any_occupied);
          errors++;
        end
      end
    end
  end

  task automatic queue_item(input req_kind_t k, input logic [11:0] p);
    req_t r;
    r.req_type = k;
    r.position = p;
    req_backlog.push_back(r);
  endtask

  // mostly requests around recently set positions, so clears empty words and
  // searches cross word boundaries; some use fixed edge positions, the rest is spread over the whole range
  task automatic queue_random_item();
    int unsigned pick;
    int unsigned src;
    logic [11:0] p;
    req_kind_t k;
    pick = $urandom_range(99);
    src = $urandom_range(99);
    if (src < 8) begin
      case ($urandom_range(4))
        0: p = 12'd0;
        1: p = 12'hfff;
        2: p = 12'd63;
        3: p = 12'd64;
        default: p = 12'hfc0;
      endcase
    end else if (src < 65 && hot_pos.size() != 0) begin
      p = hot_pos[$urandom_range(hot_pos.size() - 1)];
      if ($urandom_range(1) != 0) p[5:0] = p[5:0] ^ 6'($urandom_range(7));
    end else begin
      p = 12'($urandom);
    end
    if (pick < 30) k = REQ_SET;
    else if (pick < 45) k = REQ_CLEAR;
    else if (pick < 58) k = REQ_TEST;
    else if (pick < 65) k = REQ_HIGHEST;
    else if (pick < 72) k = REQ_LOWEST;
    else if (pick < 84) k = REQ_NEXT_UP;
    else if (pick < 97) k = REQ_NEXT_DOWN;
    else k = REQ_CLEAR_ALL;
    if (k == REQ_SET) begin
      hot_pos.push_back(p);
      if (hot_pos.size() > 16) void'(hot_pos.pop_front());
    end
    if (k == REQ_CLEAR_ALL) hot_pos.delete();
    queue_item(k, p);
  endtask

  // sender holds back until every outstanding item has come out
  task automatic wait_drained();
    @(negedge clk);
    while (!(req_backlog.size() == 0 && !req_valid && expected_results.size() == 0))
      @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // edges of the range, word boundaries, empty searches and word emptying
    queue_item(REQ_HIGHEST, 12'd0);
    queue_item(REQ_NEXT_UP, 12'd5);
    queue_item(REQ_SET, 12'd0);
    queue_item(REQ_SET, 12'hfff);
    queue_item(REQ_TEST, 12'd0);
    queue_item(REQ_TEST, 12'hfff);
    queue_item(REQ_TEST, 12'd1);
    queue_item(REQ_HIGHEST, 12'd0);
    queue_item(REQ_LOWEST, 12'hfff);
    queue_item(REQ_NEXT_UP, 12'd0);
    queue_item(REQ_NEXT_DOWN, 12'hfff);
    queue_item(REQ_NEXT_UP, 12'hfff);
    queue_item(REQ_NEXT_DOWN, 12'd0);
    queue_item(REQ_CLEAR, 12'hfff);
    queue_item(REQ_HIGHEST, 12'd0);
    queue_item(REQ_SET, 12'd63);
    queue_item(REQ_SET, 12'd64);
    queue_item(REQ_NEXT_UP, 12'd63);
    queue_item(REQ_NEXT_DOWN, 12'd64);
    queue_item(REQ_CLEAR, 12'd0);
    queue_item(REQ_CLEAR, 12'd63);
    queue_item(REQ_LOWEST, 12'd0);
    queue_item(REQ_NEXT_DOWN, 12'd64);
    queue_item(REQ_SET, 12'd2000);
    queue_item(REQ_CLEAR_ALL, 12'd2000);
    queue_item(REQ_TEST, 12'd2000);
    queue_item(REQ_LOWEST, 12'd0);
    wait_drained();

    tx_idle_pct = 32;
    rx_stall_pct = 88;
    repeat (170) queue_random_item();
    wait_drained();

    tx_idle_pct = 88;
    rx_stall_pct = 32;
    repeat (170) queue_random_item();
    wait_drained();

    // no idling; a long receiver hold lets the block fill and push back
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (40) queue_random_item();
    hold_ask = 1;
    repeat (120) queue_random_item();
    wait_drained();

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
